### rtl/prsa_pkg.sv
// Shared types and constants of the row scatter address unit.
// Used by the channel interfaces and by the scan, address and top-level modules.
package prsa_pkg;

  // Field widths of the request, result and configuration channels
  localparam int OPCODE_W   = 1;
  localparam int SLOT_W     = 7;
  localparam int BOUND_W    = 32;
  localparam int START_W    = 31;
  localparam int PART_W     = 10;
  localparam int ROW_W      = 32;
  localparam int COL_W      = 31;
  localparam int VALUE_W    = 64;
  localparam int ADDR_W     = 48;
  localparam int STRIDE_W   = 24;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Local row is (row - bound) + start and may carry one bit past 32
  localparam int LROW_W = ROW_W + 1;

  // Default table depth
  localparam int PRSA_MAX_RANGES = 64;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_ENTRY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PART  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 2'd2;

  // Configuration register file contents
  typedef struct packed {
    logic [PART_W-1:0]   keep_part;
    logic [STRIDE_W-1:0] row_stride;
    logic [COUNT_W-1:0]  range_count;
  } cfg_t;

  // Kept entry handed from the range search to the address stage
  typedef struct packed {
    logic [LROW_W-1:0]  dest_row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

### rtl/prsa_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Field widths come from prsa_pkg.
interface prsa_in_if;
  logic                           valid;
  logic                           ready;
  logic [prsa_pkg::OPCODE_W-1:0]  opcode;
  logic [prsa_pkg::SLOT_W-1:0]    table_slot;
  logic [prsa_pkg::BOUND_W-1:0]   bound_value;
  logic [prsa_pkg::START_W-1:0]   start_row;
  logic [prsa_pkg::PART_W-1:0]    owner_part;
  logic [prsa_pkg::ROW_W-1:0]     row_index;
  logic [prsa_pkg::COL_W-1:0]     col_index;
  logic [prsa_pkg::VALUE_W-1:0]   value_bits;

  modport source (output valid, opcode, table_slot, bound_value, start_row, owner_part,
                  row_index, col_index, value_bits, input ready);
  modport sink   (input valid, opcode, table_slot, bound_value, start_row, owner_part,
                  row_index, col_index, value_bits, output ready);
endinterface

interface prsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [prsa_pkg::ADDR_W-1:0]   write_address;
  logic [prsa_pkg::VALUE_W-1:0]  value_out;

  modport source (output valid, write_address, value_out, input ready);
  modport sink   (input valid, write_address, value_out, output ready);
endinterface

interface prsa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prsa_pkg::CFG_IDX_W-1:0]  index;
  logic [prsa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/prsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module prsa_ram #(
  parameter int  WIDTH  = 32,
  parameter int  DEPTH  = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; the read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/prsa_scan.sv
// Request intake, range table memories and the sequential range search.
// Depends on prsa_pkg, prsa_if and prsa_ram; hands kept entries to prsa_addr.
module prsa_scan #(
  parameter int MAX_RANGES = prsa_pkg::PRSA_MAX_RANGES
) (
  input  logic             clk,
  input  logic             rst_n,
  prsa_in_if.sink          in_ch,
  input  prsa_pkg::cfg_t   cfg,
  output logic             ent_valid,
  input  logic             ent_ready,
  output prsa_pkg::entry_t ent
);
  import prsa_pkg::*;

  localparam int BW = $clog2(MAX_RANGES + 1);
  localparam int SW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int OW = START_W + PART_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_LOOK, S_CHECK, S_HAND
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [BW-1:0]      n_r, n_nxt;
  logic [BW-1:0]      cnt_r, cnt_nxt;
  logic               tag_vld_r, tag_vld_nxt;
  logic               tag_end_r, tag_end_nxt;
  logic [BW-1:0]      tag_idx_r, tag_idx_nxt;
  logic [BOUND_W-1:0] end_bound_r, end_bound_nxt;
  logic [BW-1:0]      hit_r, hit_nxt;
  logic [BOUND_W-1:0] hit_bound_r, hit_bound_nxt;
  logic               found_r, found_nxt;
  logic [LROW_W-1:0]  lrow_r, lrow_nxt;

  logic               accept;
  logic [31:0]        slot_ext;
  logic [31:0]        rc_ext;
  logic [31:0]        n_full;
  logic               bnd_we;
  logic               so_we;
  logic [BW-1:0]      bnd_raddr;
  logic [BOUND_W-1:0] bnd_rdata;
  logic [OW-1:0]      so_rdata;
  logic [START_W-1:0] hit_start;
  logic [PART_W-1:0]  hit_owner;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Decode table writes from a load request
  assign slot_ext = {{(32 - SLOT_W){1'b0}}, in_ch.table_slot};
  assign bnd_we   = accept && (in_ch.opcode == OP_LOAD) && (slot_ext <= 32'(MAX_RANGES));
  assign so_we    = accept && (in_ch.opcode == OP_LOAD) && (slot_ext < 32'(MAX_RANGES));

  // Clamp the range count to the table depth
  assign rc_ext = {{(32 - COUNT_W){1'b0}}, cfg.range_count};
  assign n_full = (rc_ext > 32'(MAX_RANGES)) ? 32'(MAX_RANGES) : rc_ext;

  // Fetch the end bound first, then every start bound in order
  assign bnd_raddr = (cnt_r == '0) ? n_r : cnt_r - BW'(1);

  prsa_ram #(.WIDTH(BOUND_W), .DEPTH(MAX_RANGES + 1)) u_bound_ram (
    .clk   (clk),
    .we    (bnd_we),
    .waddr (slot_ext[BW-1:0]),
    .wdata (in_ch.bound_value),
    .raddr (bnd_raddr),
    .rdata (bnd_rdata)
  );

  prsa_ram #(.WIDTH(OW), .DEPTH(MAX_RANGES)) u_start_owner_ram (
    .clk   (clk),
    .we    (so_we),
    .waddr (slot_ext[SW-1:0]),
    .wdata ({in_ch.start_row, in_ch.owner_part}),
    .raddr (hit_r[SW-1:0]),
    .rdata (so_rdata)
  );

  assign hit_start = so_rdata[OW-1:PART_W];
  assign hit_owner = so_rdata[PART_W-1:0];

  assign ent_valid    = (state_r == S_HAND);
  assign ent.dest_row = lrow_r;
  assign ent.col      = col_r;
  assign ent.value    = val_r;

  // Next-state and search datapath
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    tag_vld_nxt   = 1'b0;
    tag_end_nxt   = tag_end_r;
    tag_idx_nxt   = tag_idx_r;
    end_bound_nxt = end_bound_r;
    hit_nxt       = hit_r;
    hit_bound_nxt = hit_bound_r;
    found_nxt     = found_r;
    lrow_nxt      = lrow_r;

    // Fold in the bound fetched last cycle
    if (tag_vld_r) begin
      if (tag_end_r) begin
        end_bound_nxt = bnd_rdata;
      end else if (bnd_rdata <= row_r) begin
        hit_nxt       = tag_idx_r;
        hit_bound_nxt = bnd_rdata;
        found_nxt     = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_ch.opcode == OP_ENTRY)) begin
          row_nxt   = in_ch.row_index;
          col_nxt   = in_ch.col_index;
          val_nxt   = in_ch.value_bits;
          n_nxt     = n_full[BW-1:0];
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          // An empty table drops the entry at once
          if (n_full != 32'd0) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        tag_vld_nxt = 1'b1;
        tag_end_nxt = (cnt_r == '0);
        tag_idx_nxt = cnt_r - BW'(1);
        if (cnt_r == n_r) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + BW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        lrow_nxt = {1'b0, row_r - hit_bound_r} + {{(LROW_W - START_W){1'b0}}, hit_start};
        if (found_r && (row_r < end_bound_r) && (hit_owner == cfg.keep_part)) begin
          state_nxt = S_HAND;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HAND: begin
        if (ent_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tag_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      tag_vld_r <= tag_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    val_r       <= val_nxt;
    n_r         <= n_nxt;
    tag_end_r   <= tag_end_nxt;
    tag_idx_r   <= tag_idx_nxt;
    end_bound_r <= end_bound_nxt;
    hit_r       <= hit_nxt;
    hit_bound_r <= hit_bound_nxt;
    found_r     <= found_nxt;
    lrow_r      <= lrow_nxt;
  end

endmodule

### rtl/prsa_addr.sv
// Address stage: multiplies the local row by the stride, adds the column
// and holds the result request in the output register. Depends on prsa_pkg, prsa_if.
module prsa_addr (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ent_valid,
  output logic                            ent_ready,
  input  prsa_pkg::entry_t                ent,
  input  logic [prsa_pkg::STRIDE_W-1:0]   row_stride,
  prsa_out_if.source                      out_ch
);
  import prsa_pkg::*;

  localparam int PROD_W = LROW_W + STRIDE_W;

  logic               s1_vld_r, s1_vld_nxt;
  logic [ADDR_W-1:0]  prod_r;
  logic [COL_W-1:0]   col_r;
  logic [VALUE_W-1:0] val_r;
  logic               o_vld_r, o_vld_nxt;
  logic [ADDR_W-1:0]  o_addr_r;
  logic [VALUE_W-1:0] o_val_r;
  logic [PROD_W-1:0]  prod_full;
  logic               o_free;
  logic               s1_move;

  assign o_free    = !o_vld_r || out_ch.ready;
  assign s1_move   = s1_vld_r && o_free;
  assign ent_ready = !s1_vld_r || o_free;
  assign prod_full = {{STRIDE_W{1'b0}}, ent.dest_row} * {{LROW_W{1'b0}}, row_stride};

  assign s1_vld_nxt = (ent_valid && ent_ready) || (s1_vld_r && !o_free);
  assign o_vld_nxt  = s1_move || (o_vld_r && !out_ch.ready);

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  // Register the product, wrapped to the address width
  always_ff @(posedge clk) begin
    if (ent_valid && ent_ready) begin
      prod_r <= prod_full[ADDR_W-1:0];
      col_r  <= ent.col;
      val_r  <= ent.value;
    end
  end

  // Add the column and load the output register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_addr_r <= prod_r + {{(ADDR_W - COL_W){1'b0}}, col_r};
      o_val_r  <= val_r;
    end
  end

  assign out_ch.valid         = o_vld_r;
  assign out_ch.write_address = o_addr_r;
  assign out_ch.value_out     = o_val_r;

endmodule

### rtl/partitioned_row_scatter_address_unit.sv
// Top level of the row scatter address unit: configuration registers,
// range search and address stage. Depends on prsa_pkg, prsa_if, prsa_scan, prsa_addr.
//
// The unit keeps a table of row ranges (start bound, first local row, owner part)
// in two on-chip RAMs, filled by load requests (opcode 0), one slot per request.
// An entry request (opcode 1) is searched against the table: the end bound and
// the range_count start bounds are read one per cycle from the bound RAM
// (range_count clamped to MAX_RANGES; a count of zero drops the entry at once).
// An entry holds the request side until its search ends and, if it is kept,
// until the address stage takes it. Rows in a range owned by the configured part
// and below the end bound produce one result with address (row - bound + start)
// * row_stride + column modulo 2^48; other entries and loads produce none.
// The request side reopens while a result waits in the output register. Table
// entries never loaded read back as arbitrary data. Configuration writes are
// taken every cycle and must be made while the unit is idle.
module partitioned_row_scatter_address_unit #(
  parameter int MAX_RANGES = prsa_pkg::PRSA_MAX_RANGES
) (
  input  logic       clk,
  input  logic       rst_n,
  prsa_in_if.sink    in_ch,
  prsa_out_if.source out_ch,
  prsa_cfg_if.sink   cfg_ch
);
  import prsa_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   ent_valid;
  logic   ent_ready;
  entry_t ent;

  assign cfg_ch.ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LOCAL_PART:  cfg_nxt.keep_part   = cfg_ch.data[PART_W-1:0];
        REG_ROW_STRIDE:  cfg_nxt.row_stride  = cfg_ch.data[STRIDE_W-1:0];
        REG_RANGE_COUNT: cfg_nxt.range_count = cfg_ch.data[COUNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keep_part   <= '0;
      cfg_r.row_stride  <= STRIDE_W'(1);
      cfg_r.range_count <= COUNT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  prsa_scan #(.MAX_RANGES(MAX_RANGES)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .ent_valid (ent_valid),
    .ent_ready (ent_ready),
    .ent       (ent)
  );

  prsa_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .ent_valid  (ent_valid),
    .ent_ready  (ent_ready),
    .ent        (ent),
    .row_stride (cfg_r.row_stride),
    .out_ch     (out_ch)
  );

endmodule

### sim/tb_partitioned_row_scatter_address_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the row scatter address unit: directed and random
// requests, with a mirror of the range table and configuration predicting each write.
// Depends on prsa_pkg, prsa_if and the RTL of partitioned_row_scatter_address_unit.
module tb_partitioned_row_scatter_address_unit;
  import prsa_pkg::*;

  localparam int MAX_RANGES     = PRSA_MAX_RANGES;
  localparam int SETTLE_CYCLES  = 2 * (MAX_RANGES + 6) + 16;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_REQUESTS = 124;
  localparam int MAX_REPORTS    = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   table_slot;
    logic [BOUND_W-1:0]  bound_value;
    logic [START_W-1:0]  start_row;
    logic [PART_W-1:0]   owner_part;
    logic [ROW_W-1:0]    row_index;
    logic [COL_W-1:0]    col_index;
    logic [VALUE_W-1:0]  value_bits;
  } scatter_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  write_address;
    logic [VALUE_W-1:0] value_out;
  } scatter_write_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic clk;
  logic rst_n;

  prsa_in_if  in_ch();
  prsa_out_if out_ch();
  prsa_cfg_if cfg_ch();

  partitioned_row_scatter_address_unit #(.MAX_RANGES(MAX_RANGES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the range table and the configuration registers
  logic [BOUND_W-1:0]  bound_mem [MAX_RANGES+1];
  logic [START_W-1:0]  start_mem [MAX_RANGES];
  logic [PART_W-1:0]   owner_mem [MAX_RANGES];
  logic [PART_W-1:0]   part_reg;
  logic [STRIDE_W-1:0] stride_reg;
  logic [COUNT_W-1:0]  count_reg;

  scatter_write_t pending_writes[$];

  int mismatch_count;
  int requests_sent;
  int entries_sent;
  int writes_checked;
  int phases_run;
  int burst_left;

  rx_pattern_t rx_mode;
  int          rx_left;
  int          rx_tick;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run far beyond the slowest legal schedule
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int active_ranges();
    return (count_reg > MAX_RANGES) ? MAX_RANGES : int'(count_reg);
  endfunction

  // Apply a load request to the mirrored table; slots past the end bound are dropped
  function automatic void mirror_load(scatter_req_t r);
    if (r.table_slot <= MAX_RANGES) bound_mem[r.table_slot] = r.bound_value;
    if (r.table_slot < MAX_RANGES) begin
      start_mem[r.table_slot] = r.start_row;
      owner_mem[r.table_slot] = r.owner_part;
    end
  endfunction

  // Find the range of the row and form the flat local address, if the row is kept
  function automatic bit predict_write(scatter_req_t r, output scatter_write_t w);
    int n;
    int hit;
    bit found;
    logic [31:0] row_off;
    logic [63:0] lrow;
    logic [63:0] addr;
    n = active_ranges();
    found = 1'b0;
    hit = 0;
    w.write_address = '0;
    w.value_out = r.value_bits;
    if (n == 0) return 1'b0;
    if (r.row_index >= bound_mem[n]) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (bound_mem[i] <= r.row_index) begin
        hit = i;
        found = 1'b1;
      end
    end
    if (!found) return 1'b0;
    if (owner_mem[hit] != part_reg) return 1'b0;
    row_off = r.row_index - bound_mem[hit];
    lrow = {32'b0, row_off} + {33'b0, start_mem[hit]};
    addr = lrow * {40'b0, stride_reg} + {33'b0, r.col_index};
    w.write_address = addr[ADDR_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Compare each accepted write with the oldest prediction
  always @(posedge clk) begin
    scatter_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      writes_checked++;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write addr %h value %h",
                                  out_ch.write_address, out_ch.value_out));
      end else begin
        want = pending_writes.pop_front();
        if (out_ch.write_address !== want.write_address)
          report_mismatch($sformatf("write_address %h, predicted %h",
                                    out_ch.write_address, want.write_address));
        if (out_ch.value_out !== want.value_out)
          report_mismatch($sformatf("value_out %h, predicted %h",
                                    out_ch.value_out, want.value_out));
      end
    end
  end

  // Stall the result side on a changing pattern
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   out_ch.ready <= ((rx_tick % 7) < 4);
    endcase
  end

  // Drive one request, wait for it to be taken, predict, then maybe open a gap
  task automatic send_request(scatter_req_t r);
    scatter_write_t w;
    int gap;
    int roll;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= r.opcode;
    in_ch.table_slot  <= r.table_slot;
    in_ch.bound_value <= r.bound_value;
    in_ch.start_row   <= r.start_row;
    in_ch.owner_part  <= r.owner_part;
    in_ch.row_index   <= r.row_index;
    in_ch.col_index   <= r.col_index;
    in_ch.value_bits  <= r.value_bits;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    if (r.opcode == OP_LOAD) begin
      mirror_load(r);
    end else begin
      entries_sent++;
      if (predict_write(r, w)) pending_writes.push_back(w);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      roll = $urandom_range(0, 19);
      if (roll < 1)       gap = $urandom_range(11, 30);
      else if (roll < 6)  gap = $urandom_range(4, 10);
      else if (roll < 14) gap = $urandom_range(1, 3);
      else                gap = 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic scatter_req_t random_request();
    scatter_req_t r;
    r.opcode      = 1'($urandom_range(0, 1));
    r.table_slot  = 7'($urandom);
    r.bound_value = $urandom;
    r.start_row   = 31'($urandom);
    r.owner_part  = 10'($urandom);
    r.row_index   = $urandom;
    r.col_index   = 31'($urandom);
    r.value_bits  = {$urandom, $urandom};
    return r;
  endfunction

  task automatic send_load(logic [SLOT_W-1:0] slot, logic [BOUND_W-1:0] bound,
                           logic [START_W-1:0] start, logic [PART_W-1:0] owner);
    scatter_req_t r;
    r = random_request();
    r.opcode      = OP_LOAD;
    r.table_slot  = slot;
    r.bound_value = bound;
    r.start_row   = start;
    r.owner_part  = owner;
    send_request(r);
  endtask

  task automatic send_entry(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [VALUE_W-1:0] value);
    scatter_req_t r;
    r = random_request();
    r.opcode     = OP_ENTRY;
    r.row_index  = row;
    r.col_index  = col;
    r.value_bits = value;
    send_request(r);
  endtask

  // Write one register, then leave the channel idle so writes never abut
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_LOCAL_PART:  part_reg   = data[PART_W-1:0];
      REG_ROW_STRIDE:  stride_reg = data[STRIDE_W-1:0];
      REG_RANGE_COUNT: count_reg  = data[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted write, then let silent requests drain
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Fill the whole table: range s starts at 100 + 16*s, last range runs to near the top
  task automatic test_defaults_after_reset();
    logic [BOUND_W-1:0] b;
    logic [START_W-1:0] st;
    logic [PART_W-1:0]  own;
    for (int s = 0; s <= MAX_RANGES; s++) begin
      b   = (s < MAX_RANGES) ? 32'(100 + 16 * s) : 32'hFFFF_FFF0;
      st  = (s == MAX_RANGES - 1) ? 31'h7FFF_FFFF : 31'(16 * s);
      own = (s == MAX_RANGES - 1) ? 10'd1023 : ((s % 4 == 0) ? 10'd0 : 10'(s));
      send_load(7'(s), b, st, own);
    end
    // One range, part 0, unit stride: first and last row kept, both neighbors dropped
    send_entry(32'd100, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_entry(32'd115, 31'd0, 64'd0);
    send_entry(32'd99, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_entry(32'd116, 31'd5, 64'h0123_4567_89AB_CDEF);
  endtask

  // Full table, top part id and top stride: wrapped address, end bound, foreign owner, row below the first bound
  task automatic test_lookup_extremes();
    settle_idle();
    write_register(REG_LOCAL_PART, 24'hFF_FFFF);
    write_register(REG_ROW_STRIDE, 24'hFF_FFFF);
    write_register(REG_RANGE_COUNT, 24'd64);
    send_entry(32'hFFFF_FFEF, 31'h7FFF_FFFF, {$urandom, $urandom});
    send_entry(32'hFFFF_FFFF, 31'd1, {$urandom, $urandom});
    send_entry(32'd1107, 31'd2, {$urandom, $urandom});
    send_entry(32'd0, 31'd3, {$urandom, $urandom});
  endtask

  // Final slot takes only its bound; slots past it must not alias onto low slots
  task automatic test_special_loads();
    send_load(7'd64, 32'hFFFF_FFFF, 31'($urandom), 10'($urandom));
    send_load(7'd65, 32'd0, 31'd0, 10'd1023);
    send_load(7'd127, 32'd0, 31'd0, 10'd0);
    send_entry(32'hFFFF_FFFF, 31'h7FFF_FFFF, 64'd0);
    send_entry(32'd1110, 31'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_entry(32'd50, 31'd9, {$urandom, $urandom});
  endtask

  // Count of zero, clamped count, spare index, zero and top stride
  task automatic test_register_extremes();
    settle_idle();
    write_register(REG_RANGE_COUNT, 24'd0);
    send_entry(32'd1110, 31'd4, {$urandom, $urandom});
    settle_idle();
    write_register(REG_SPARE, 24'hFF_FFFF);
    write_register(REG_RANGE_COUNT, 24'hFF_FFFF);
    write_register(REG_ROW_STRIDE, 24'd0);
    write_register(REG_LOCAL_PART, 24'hFF_FC00);
    send_entry(32'd164, 31'h7FFF_FFFF, {$urandom, $urandom});
    send_entry(32'd100, 31'd11, {$urandom, $urandom});
    settle_idle();
    write_register(REG_ROW_STRIDE, 24'hFF_FFFF);
    send_entry(32'd164, 31'h7FFF_FFFF, {$urandom, $urandom});
  endtask

  // Load a sorted partition over slots 0..n, mostly owned by the local part
  task automatic build_partition(int n);
    longint cur;
    longint step_cap;
    logic [BOUND_W-1:0] b;
    logic [PART_W-1:0]  own;
    bit wide;
    wide = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 3))
      0:       cur = 0;
      1:       cur = $urandom_range(0, 255);
      default: cur = $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    step_cap = wide ? (64'hFFFF_FFFF - cur) / (n + 1) : 48;
    for (int s = 0; s <= n; s++) begin
      b = (cur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cur[31:0];
      if (s == n && $urandom_range(0, 3) == 0) b = 32'hFFFF_FFFF;
      own = ($urandom_range(0, 9) < 6) ? part_reg : 10'($urandom);
      send_load(7'(s), b, 31'($urandom), own);
      if ($urandom_range(0, 7) != 0) cur = cur + $urandom_range(1, 32'(step_cap));
    end
  endtask

  // Mostly rows inside a live range, some random rows, some stray loads
  task automatic send_random_item();
    scatter_req_t r;
    int n;
    int k;
    int pick;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    r = random_request();
    n = active_ranges();
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      r.opcode = OP_LOAD;
    end else begin
      r.opcode = OP_ENTRY;
      if (pick >= 4 && n > 0) begin
        k = $urandom_range(0, n - 1);
        lo = {32'b0, bound_mem[k]};
        hi = {32'b0, bound_mem[k+1]};
        span = (hi > lo) ? hi - lo : 64'd1;
        case ($urandom_range(0, 4))
          0:       r.row_index = lo[31:0];
          1:       r.row_index = 32'(lo + span - 1);
          default: r.row_index = 32'(lo + ({$urandom, $urandom} % span));
        endcase
      end
    end
    send_request(r);
  endtask

  // Phases of fresh configuration, fresh table, then random traffic
  task automatic test_random_phases();
    int plan [RANDOM_PHASES] = '{3, 64, 1, 8, 100, 5, 0, 2, 16, 127, 6, 33};
    logic [PART_W-1:0]   part;
    logic [STRIDE_W-1:0] stride;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_idle();
      case ($urandom_range(0, 3))
        0:       part = '0;
        1:       part = '1;
        default: part = 10'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       stride = '0;
        1:       stride = 24'd1;
        2:       stride = '1;
        3:       stride = 24'($urandom);
        default: stride = 24'($urandom_range(1, 4096));
      endcase
      write_register(REG_LOCAL_PART, {14'($urandom), part});
      write_register(REG_ROW_STRIDE, stride);
      write_register(REG_RANGE_COUNT, {17'($urandom), 7'(plan[p])});
      build_partition(active_ranges());
      repeat (PHASE_REQUESTS) send_random_item();
      phases_run++;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_LOAD;
    in_ch.table_slot  = '0;
    in_ch.bound_value = '0;
    in_ch.start_row   = '0;
    in_ch.owner_part  = '0;
    in_ch.row_index   = '0;
    in_ch.col_index   = '0;
    in_ch.value_bits  = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_LOCAL_PART;
    cfg_ch.data       = '0;
    part_reg          = '0;
    stride_reg        = 24'd1;
    count_reg         = 7'd1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults_after_reset();
    test_lookup_extremes();
    test_special_loads();
    test_register_extremes();
    test_random_phases();
    settle_idle();

    $display("Covered %0d requests (%0d entries): directed edges plus %0d random phases.",
             requests_sent, entries_sent, phases_run);
    $display("Compared %0d scatter writes, %0d mismatches.", writes_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/prsa_pkg.sv
rtl/prsa_if.sv
rtl/prsa_ram.sv
rtl/prsa_scan.sv
rtl/prsa_addr.sv
rtl/partitioned_row_scatter_address_unit.sv
sim/tb_partitioned_row_scatter_address_unit.sv
